/* design/kpfp_pkg.sv */
// Package for the keypoint frame parser: frame layout constants, record
// lane codes, register indexes and the types shared by the top level and
// the record memory. Depends on nothing.
`default_nettype none

package kpfp_pkg;

  // Register indexes on the write port
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_TAIL   = 1'b1;

  // Frame layout
  localparam logic [7:0] KP_TYPE      = 8'h10;
  localparam logic [5:0] KP_FRAME_LEN = 6'd36;
  localparam logic [5:0] KP_SEQ_IDX   = 6'd3;
  localparam logic [5:0] KP_XY_BASE   = 6'd4;
  localparam logic [5:0] KP_CONF_BASE = 6'd28;
  localparam logic [5:0] KP_CONF_END  = 6'd33;
  localparam logic [2:0] KP_LAST_JOINT = 3'd5;
  localparam int         MIN_FRAME_LEN = 4;
  localparam int         MAX_FRAME_LEN = 36;

  // Byte lanes of one joint record: x (16), y (16), confidence (8)
  localparam logic [2:0] LANE_X_LO = 3'd0;
  localparam logic [2:0] LANE_X_HI = 3'd1;
  localparam logic [2:0] LANE_Y_LO = 3'd2;
  localparam logic [2:0] LANE_Y_HI = 3'd3;
  localparam logic [2:0] LANE_CONF = 3'd4;

  localparam int REC_W      = 40;
  localparam int REC_ADDR_W = 4;   // {bank, joint}
  localparam int DESC_DEPTH = 4;
  localparam int DESC_PTR_W = 2;

  typedef struct packed {
    logic                  en;
    logic [REC_ADDR_W-1:0] addr;
    logic [2:0]            lane;
    logic [7:0]            data;
  } rec_wr_t;

  typedef struct packed {
    logic                  en;
    logic [REC_ADDR_W-1:0] addr;
  } rec_rd_t;

  // One accepted frame waiting for its results
  typedef struct packed {
    logic        kp;
    logic [7:0]  ftype;
    logic [7:0]  seq;
    logic        bank;
    logic [31:0] count;
  } desc_t;

endpackage

`default_nettype wire

/* design/kpfp_rec_mem.sv */
// Joint record memory: two banks of six 40-bit records, byte-lane writes,
// one registered read port. Depends on kpfp_pkg.
`default_nettype none

module kpfp_rec_mem
  import kpfp_pkg::*;
(
  input  wire logic             clk,
  input  wire rec_wr_t          wr,
  input  wire rec_rd_t          rd,
  output logic [REC_W-1:0]      rd_data_r
);

  logic [REC_W-1:0] mem [0:(1<<REC_ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      unique case (wr.lane)
        LANE_X_LO: mem[wr.addr][7:0]   <= wr.data;
        LANE_X_HI: mem[wr.addr][15:8]  <= wr.data;
        LANE_Y_LO: mem[wr.addr][23:16] <= wr.data;
        LANE_Y_HI: mem[wr.addr][31:24] <= wr.data;
        LANE_CONF: mem[wr.addr][39:32] <= wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

/* design/xor_checked_keypoint_frame_parser_top.sv */
// Top level of the XOR-checked keypoint frame parser: byte parser, frame
// queue and result drain around the joint record memory.
// Depends on kpfp_pkg and kpfp_rec_mem.
//
//   port group | dir | width          | contents
//   -----------+-----+----------------+----------------------------------------
//   in_*       | in  | tdata 8        | rx_byte, one request per received byte
//   out_*      | out | tdata 96, u 1  | zero, one or six results per request
//   cfg_*      | in  | addr 1, data 8 | 0 header_byte, 1 tail_byte
//
// One byte is taken per cycle while the input is not stalled. Header, type,
// sequence, checksum and tail are held in registers; the joint bytes of a
// keypoint frame go straight into a record in one of two memory banks. Each
// result passes through the drain as a memory read, then the output register,
// and the drain starts no new read while one is pending. Reset is synchronous,
// active low, and clears all control state; the memory needs no clearing. The
// input stalls only while the frame queue is full or while a keypoint byte
// would land in a bank whose results are still waiting on the output.
`default_nettype none

module xor_checked_keypoint_frame_parser_top
  import kpfp_pkg::*;
#(
  parameter int SHORT_FRAME_LEN = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // out_tdata: [7:0] frame_type, [15:8] sequence_res, [18:16] joint,
  // [34:19] pos_x, [50:35] pos_y, [58:51] confidence, [90:59] valid_frames,
  // [95:91] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,
  // out_tuser: [0] is_keypoint
  output logic             out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int SHORT_CLAMP = (SHORT_FRAME_LEN < MIN_FRAME_LEN) ? MIN_FRAME_LEN :
                               (SHORT_FRAME_LEN > MAX_FRAME_LEN) ? MAX_FRAME_LEN :
                               SHORT_FRAME_LEN;
  localparam logic [5:0] SHORT_LEN = 6'(SHORT_CLAMP);

  // ---------------- configuration ----------------
  logic [7:0] header_r, tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= 8'hAA;
      tail_r   <= 8'h55;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_HEADER: header_r <= cfg_wdata;
        REG_TAIL:   tail_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- parser state ----------------
  logic        in_frame_r;
  logic [5:0]  idx_r, len_r;
  logic [7:0]  xor_r, chk_r, type_r, seq_r;
  logic [31:0] cnt_r;
  logic        wr_bank_r;
  logic [1:0]  bank_busy_r;

  // frame queue
  desc_t                 dq_r [0:DESC_DEPTH-1];
  logic [DESC_PTR_W-1:0] dq_head_r, dq_tail_r;
  logic [DESC_PTR_W:0]   dq_cnt_r;
  logic                  dq_full, dq_push, dq_pop;
  desc_t                 dq_in, dq_head;

  logic       in_acc;
  logic [7:0] b;
  logic [5:0] len_cur;
  logic       frame_end, frame_good, kp_good;
  logic       kp_byte;
  logic [4:0] xy_off;
  logic [2:0] wr_joint, wr_lane;
  logic       bank_clr;
  logic       clr_bank;

  rec_wr_t rec_wr;
  rec_rd_t rec_rd;
  logic [REC_W-1:0] rec_rd_data;

  assign b       = in_tdata;
  assign dq_full = (dq_cnt_r == (DESC_PTR_W+1)'(DESC_DEPTH));

  // Joint bytes of a keypoint frame: x/y groups at 4..27, confidence at 28..33
  assign kp_byte = in_frame_r && (type_r == KP_TYPE) && (len_r == KP_FRAME_LEN) &&
                   (idx_r >= KP_XY_BASE) && (idx_r <= KP_CONF_END);
  assign xy_off  = 5'(idx_r - KP_XY_BASE);

  always_comb begin
    if (idx_r < KP_CONF_BASE) begin
      wr_joint = xy_off[4:2];
      wr_lane  = {1'b0, xy_off[1:0]};
    end else begin
      wr_joint = 3'(idx_r - KP_CONF_BASE);
      wr_lane  = LANE_CONF;
    end
  end

  // Hold the input while full or while the target bank still drains
  assign in_tready = !dq_full && !(kp_byte && bank_busy_r[wr_bank_r]);
  assign in_acc    = in_tvalid && in_tready;

  assign len_cur    = (idx_r == 6'd1) ? ((b == KP_TYPE) ? KP_FRAME_LEN : SHORT_LEN) : len_r;
  assign frame_end  = in_acc && in_frame_r && (idx_r == len_cur - 6'd1);
  assign frame_good = frame_end && (b == tail_r) && (chk_r == xor_r);
  assign kp_good    = frame_good && (type_r == KP_TYPE) && (len_r == KP_FRAME_LEN);

  always_comb begin
    rec_wr.en   = in_acc && kp_byte;
    rec_wr.addr = {wr_bank_r, wr_joint};
    rec_wr.lane = wr_lane;
    rec_wr.data = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      idx_r      <= 6'd0;
      len_r      <= SHORT_LEN;
      xor_r      <= 8'd0;
      cnt_r      <= 32'd0;
      wr_bank_r  <= 1'b0;
    end else if (in_acc) begin
      if (!in_frame_r) begin
        if (b == header_r) begin
          in_frame_r <= 1'b1;
          idx_r      <= 6'd1;
          len_r      <= SHORT_LEN;
          xor_r      <= b;
        end
      end else begin
        len_r <= len_cur;
        if (({1'b0, idx_r} + 7'd2) < {1'b0, len_cur}) begin
          xor_r <= xor_r ^ b;
        end
        if (frame_end) begin
          in_frame_r <= 1'b0;
          idx_r      <= 6'd0;
          xor_r      <= 8'd0;
        end else begin
          idx_r <= idx_r + 6'd1;
        end
        if (frame_good) begin
          cnt_r <= cnt_r + 32'd1;
        end
        if (kp_good) begin
          wr_bank_r <= !wr_bank_r;
        end
      end
    end
  end

  // Payload captures of the type, sequence and checksum bytes
  always_ff @(posedge clk) begin
    if (in_acc && in_frame_r) begin
      if (idx_r == 6'd1) type_r <= b;
      if (idx_r == KP_SEQ_IDX) seq_r <= b;
      if (idx_r == len_cur - 6'd2) chk_r <= b;
    end
  end

  // ---------------- frame queue ----------------
  always_comb begin
    dq_in.kp    = kp_good;
    dq_in.ftype = type_r;
    dq_in.seq   = seq_r;
    dq_in.bank  = wr_bank_r;
    dq_in.count = cnt_r + 32'd1;
  end

  assign dq_push = frame_good;
  assign dq_head = dq_r[dq_head_r];

  always_ff @(posedge clk) begin
    if (dq_push) begin
      dq_r[dq_tail_r] <= dq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dq_head_r <= '0;
      dq_tail_r <= '0;
      dq_cnt_r  <= '0;
    end else begin
      if (dq_push) dq_tail_r <= dq_tail_r + DESC_PTR_W'(1);
      if (dq_pop)  dq_head_r <= dq_head_r + DESC_PTR_W'(1);
      dq_cnt_r <= dq_cnt_r + (DESC_PTR_W+1)'(dq_push) - (DESC_PTR_W+1)'(dq_pop);
    end
  end

  // ---------------- result drain ----------------
  logic        rd_pend_r;
  logic [2:0]  joint_r;
  logic        issue;
  logic        m_kp_r, m_last_r;
  logic [7:0]  m_type_r, m_seq_r;
  logic [2:0]  m_joint_r;
  logic [31:0] m_count_r;
  logic        out_tvalid_r;

  assign issue    = (dq_cnt_r != '0) && !rd_pend_r && (!out_tvalid_r || out_tready);
  assign dq_pop   = issue && (!dq_head.kp || (joint_r == KP_LAST_JOINT));
  assign bank_clr = dq_pop && dq_head.kp;
  assign clr_bank = dq_head.bank;

  always_comb begin
    rec_rd.en   = issue && dq_head.kp;
    rec_rd.addr = {dq_head.bank, joint_r};
  end

  kpfp_rec_mem u_rec_mem (
    .clk       (clk),
    .wr        (rec_wr),
    .rd        (rec_rd),
    .rd_data_r (rec_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_busy_r <= 2'b00;
    end else begin
      if (bank_clr) bank_busy_r[clr_bank] <= 1'b0;
      if (kp_good)  bank_busy_r[wr_bank_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r    <= 1'b0;
      joint_r      <= 3'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_pend_r <= issue;
      if (issue) begin
        joint_r <= dq_pop ? 3'd0 : joint_r + 3'd1;
      end
      // The output register is always empty while a read is pending
      if (rd_pend_r) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_kp_r    <= dq_head.kp;
      m_type_r  <= dq_head.ftype;
      m_seq_r   <= dq_head.seq;
      m_joint_r <= joint_r;
      m_count_r <= dq_head.count;
      m_last_r  <= dq_pop;
    end
  end

  logic [95:0] out_data_r;
  logic        out_user_r, out_last_r;

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_user_r <= m_kp_r;
      out_last_r <= m_last_r;
      if (m_kp_r) begin
        out_data_r <= {5'd0, m_count_r, rec_rd_data[39:32], rec_rd_data[31:16],
                       rec_rd_data[15:0], m_joint_r, m_seq_r, m_type_r};
      end else begin
        out_data_r <= {5'd0, m_count_r, 51'd0, m_type_r};
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // ---------------- checks ----------------
  a_pend_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_tvalid_r)
    else $error("read returned while output register still full");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dq_cnt_r <= (DESC_PTR_W+1)'(DESC_DEPTH))
    else $error("frame queue overflow");

  a_no_busy_write: assert property (@(posedge clk) disable iff (!rst_n)
    rec_wr.en |-> !bank_busy_r[wr_bank_r])
    else $error("record write into a bank still draining");

  a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_user_r) |-> out_last_r)
    else $error("non-keypoint result not marked last");

  a_kp_pop_bank_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rec_rd.en |-> bank_busy_r[dq_head.bank])
    else $error("keypoint read from a bank that holds no frame");

endmodule

`default_nettype wire

/* bench/xor_checked_keypoint_frame_parser_top_tb.sv */
// Self-checking bench for xor_checked_keypoint_frame_parser_top: drives byte
// streams of good, damaged and cut frames and checks every result record.
// Depends on kpfp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module xor_checked_keypoint_frame_parser_top_tb;
  import kpfp_pkg::*;

  // Short frame length as the parser clamps it
  localparam int SHORT_LEN = 12;
  localparam int FRAME_LEN_SHORT = (SHORT_LEN < MIN_FRAME_LEN) ? MIN_FRAME_LEN :
                                   (SHORT_LEN > MAX_FRAME_LEN) ? MAX_FRAME_LEN : SHORT_LEN;
  localparam logic [7:0] HEADER_RESET = 8'hAA;
  localparam logic [7:0] TAIL_RESET   = 8'h55;
  localparam int JOINTS        = 6;
  localparam int MAX_GAP       = 18;
  localparam int LONG_HOLD     = 600;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_BYTES   = 100;

  // Ways a generated frame can be damaged
  typedef enum int {FLAW_NONE, FLAW_XOR, FLAW_TAIL, FLAW_CUT} frame_flaw_t;

  // One result record as it leaves the parser
  typedef struct packed {
    logic        kp;
    logic [7:0]  ftype;
    logic [7:0]  seq;
    logic [2:0]  joint;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  conf;
    logic [31:0] count;
    logic        lst;
  } kp_record_t;

  // Scoreboard: keeps its own copy of the parser state, turns every
  // accepted byte into the records it must produce, and checks records
  // against them in order.
  class frame_scoreboard;
    logic [7:0]  header_byte;
    logic [7:0]  tail_byte;
    bit          in_frame;
    int          byte_idx;
    int          frame_len;
    int          short_len;
    logic [7:0]  run_xor;
    logic [7:0]  frame_bytes [0:MAX_FRAME_LEN-1];
    logic [31:0] frames_ok;
    kp_record_t  pending_records [$];
    int          mismatches;
    int          records_checked;

    function new(int short_len_i);
      short_len       = short_len_i;
      header_byte     = HEADER_RESET;
      tail_byte       = TAIL_RESET;
      in_frame        = 1'b0;
      byte_idx        = 0;
      frame_len       = short_len_i;
      run_xor         = 8'h00;
      frames_ok       = 32'd0;
      mismatches      = 0;
      records_checked = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] v);
      if (idx == REG_HEADER) header_byte = v;
      else if (idx == REG_TAIL) tail_byte = v;
    endfunction

    function void take_byte(logic [7:0] b);
      kp_record_t rec;
      int p;
      if (!in_frame) begin
        if (b == header_byte) begin
          frame_bytes[0] = b;
          byte_idx       = 1;
          frame_len      = short_len;
          run_xor        = b;
          in_frame       = 1'b1;
        end
        return;
      end
      frame_bytes[byte_idx] = b;
      if (byte_idx == 1)
        frame_len = (b == KP_TYPE) ? int'(KP_FRAME_LEN) : short_len;
      // checksum covers everything ahead of the checksum byte
      if (byte_idx + 2 < frame_len) run_xor ^= b;
      byte_idx++;
      if (byte_idx < frame_len) return;

      in_frame = 1'b0;
      byte_idx = 0;
      if (frame_bytes[frame_len-1] != tail_byte || frame_bytes[frame_len-2] != run_xor) begin
        run_xor = 8'h00;
        return;
      end
      run_xor   = 8'h00;
      frames_ok = frames_ok + 32'd1;

      if (frame_bytes[1] == KP_TYPE && frame_len == int'(KP_FRAME_LEN)) begin
        for (int j = 0; j < JOINTS; j++) begin
          p         = int'(KP_XY_BASE) + 4 * j;
          rec.kp    = 1'b1;
          rec.ftype = frame_bytes[1];
          rec.seq   = frame_bytes[KP_SEQ_IDX];
          rec.joint = 3'(j);
          rec.x     = {frame_bytes[p+1], frame_bytes[p]};
          rec.y     = {frame_bytes[p+3], frame_bytes[p+2]};
          rec.conf  = frame_bytes[int'(KP_CONF_BASE) + j];
          rec.count = frames_ok;
          rec.lst   = (3'(j) == KP_LAST_JOINT);
          pending_records.push_back(rec);
        end
      end else begin
        rec       = '0;
        rec.ftype = frame_bytes[1];
        rec.count = frames_ok;
        rec.lst   = 1'b1;
        pending_records.push_back(rec);
      end
    endfunction

    function void check_record(logic [95:0] data, logic user, logic lst);
      kp_record_t got;
      kp_record_t want;
      string      bad;
      got.kp    = user;
      got.ftype = data[7:0];
      got.seq   = data[15:8];
      got.joint = data[18:16];
      got.x     = data[34:19];
      got.y     = data[50:35];
      got.conf  = data[58:51];
      got.count = data[90:59];
      got.lst   = lst;
      records_checked++;
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kp=%0d type=%02h seq=%02h",
                   $realtime, got.kp, got.ftype, got.seq,
                   " joint=%0d x=%04h y=%04h", got.joint, got.x, got.y);
        return;
      end
      want = pending_records.pop_front();
      bad  = "";
      if (got.kp    !== want.kp)    bad = {bad, " is_keypoint"};
      if (got.ftype !== want.ftype) bad = {bad, " frame_type"};
      if (got.seq   !== want.seq)   bad = {bad, " sequence_res"};
      if (got.joint !== want.joint) bad = {bad, " joint"};
      if (got.x     !== want.x)     bad = {bad, " pos_x"};
      if (got.y     !== want.y)     bad = {bad, " pos_y"};
      if (got.conf  !== want.conf)  bad = {bad, " confidence"};
      if (got.count !== want.count) bad = {bad, " valid_frames"};
      if (got.lst   !== want.lst)   bad = {bad, " last"};
      if (data[95:91] !== 5'd0)     bad = {bad, " padding"};
      if (bad.len() != 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %0d wrong in%s", $realtime, records_checked, bad);
          $display("  expected kp=%0d type=%02h seq=%02h joint=%0d",
                   want.kp, want.ftype, want.seq, want.joint,
                   " x=%04h y=%04h conf=%02h cnt=%0d last=%0d",
                   want.x, want.y, want.conf, want.count, want.lst);
          $display("  actual   kp=%0d type=%02h seq=%02h joint=%0d",
                   got.kp, got.ftype, got.seq, got.joint,
                   " x=%04h y=%04h conf=%02h cnt=%0d last=%0d",
                   got.x, got.y, got.conf, got.count, got.lst);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  wire logic   in_tready;
  logic [7:0]  in_tdata;
  wire logic   out_tvalid;
  logic        out_tready;
  wire logic [95:0] out_tdata;
  wire logic   out_tuser;
  wire logic   out_tlast;
  logic        cfg_wr_en;
  logic        cfg_addr;
  logic [7:0]  cfg_wdata;

  frame_scoreboard sb;

  // Frame under construction
  logic [7:0] frame_buf [0:MAX_FRAME_LEN-1];
  int         frame_n;

  // Idle shaping: burst modes drop all gaps, long_hold makes the sender
  // push back-to-back while the result side is held off
  bit in_burst;
  bit out_burst;
  bit long_hold;

  int bytes_sent;
  int frames_sent;
  int kp_frames_sent;
  int flawed_frames;
  int results_taken;

  xor_checked_keypoint_frame_parser_top #(
    .SHORT_FRAME_LEN(SHORT_LEN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Payload byte: lean on the extremes and on the header value, which must
  // be taken as plain data inside a frame
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return sb.header_byte;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Line noise between frames; never the header so it cannot open a frame
  function automatic logic [7:0] pick_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == sb.header_byte);
    return b;
  endfunction

  // Offer one byte and hold it until the parser takes it. Keep valid high
  // after the handshake; the next call lowers it only if it idles first.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (in_burst || long_hold) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  // Header, type and random body; checksum and tail come from seal_frame
  task automatic fill_frame(input bit kp);
    logic [7:0] t;
    frame_n = kp ? int'(KP_FRAME_LEN) : FRAME_LEN_SHORT;
    if (kp) begin
      t = KP_TYPE;
    end else begin
      do t = pick_byte(); while (t == KP_TYPE);
    end
    frame_buf[0] = sb.header_byte;
    frame_buf[1] = t;
    for (int i = 2; i < frame_n - 2; i++) frame_buf[i] = pick_byte();
  endtask

  task automatic seal_frame(input frame_flaw_t flaw);
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < frame_n - 2; i++) x ^= frame_buf[i];
    frame_buf[frame_n-2] = x;
    frame_buf[frame_n-1] = sb.tail_byte;
    case (flaw)
      FLAW_XOR:  frame_buf[frame_n-2] ^= 8'($urandom_range(1, 255));
      FLAW_TAIL: frame_buf[frame_n-1] ^= 8'($urandom_range(1, 255));
      // cut short: the rest of it is made of whatever comes next
      FLAW_CUT:  frame_n = $urandom_range(2, frame_n - 1);
      default: ;
    endcase
    if (flaw != FLAW_NONE) flawed_frames++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_n; i++) send_byte(frame_buf[i]);
    frames_sent++;
    if (frame_buf[1] == KP_TYPE) kp_frames_sent++;
  endtask

  // Wait for every predicted record, then give the parser time to finish
  // any frame it is still closing that produces nothing
  task automatic drain_results();
    int guard;
    guard = 0;
    while (sb.pending_records.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] hdr, input logic [7:0] tl);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_HEADER;
    cfg_wdata <= hdr;
    @(posedge clk);
    sb.write_reg(REG_HEADER, hdr);
    cfg_addr  <= REG_TAIL;
    cfg_wdata <= tl;
    @(posedge clk);
    sb.write_reg(REG_TAIL, tl);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, some damaged or cut,
  // a little noise between them. Close any open frame before the next one
  // so good frames stay aligned, and close the last one before draining.
  task automatic run_phase(input int budget);
    int          start;
    int          roll;
    frame_flaw_t flaw;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      in_burst = ($urandom_range(0, 3) == 0);
      while (sb.in_frame) send_byte(pick_byte());
      repeat ($urandom_range(0, 2)) send_byte(pick_noise());
      fill_frame($urandom_range(0, 9) < 4);
      roll = $urandom_range(0, 19);
      flaw = (roll < 12) ? FLAW_NONE : (roll < 15) ? FLAW_XOR :
             (roll < 17) ? FLAW_TAIL : FLAW_CUT;
      seal_frame(flaw);
      send_frame();
    end
    while (sb.in_frame) send_byte(pick_byte());
    in_tvalid <= 1'b0;
    drain_results();
  endtask

  // Result side: random stalls, stall-free stretches, and two long
  // hold-offs that back the parser up into its input
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    out_burst  = 1'b0;
    long_hold  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken % 16 == 0) out_burst = ($urandom_range(0, 2) == 0);
      stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ((results_taken == 10 || results_taken == 60) && !long_hold) begin
        long_hold = 1'b1;
        stall     = LONG_HOLD;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      long_hold = 1'b0;
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_record(out_tdata, out_tuser, out_tlast);
      results_taken++;
    end
  end

  initial begin : stimulus
    sb             = new(FRAME_LEN_SHORT);
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    cfg_wr_en      = 1'b0;
    cfg_addr       = REG_HEADER;
    cfg_wdata      = 8'h00;
    in_burst       = 1'b0;
    bytes_sent     = 0;
    frames_sent    = 0;
    kp_frames_sent = 0;
    flawed_frames  = 0;
    results_taken  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme noise bytes, a good short frame carrying 0x00, 0xFF,
    // the header value and the keypoint type as payload (no resync), then a
    // short frame with a broken checksum that must vanish
    send_byte(8'h00);
    send_byte(8'hFF);
    fill_frame(1'b0);
    frame_buf[2] = 8'h00;
    frame_buf[3] = 8'hFF;
    frame_buf[4] = sb.header_byte;
    frame_buf[5] = KP_TYPE;
    seal_frame(FLAW_NONE);
    send_frame();
    fill_frame(1'b0);
    seal_frame(FLAW_XOR);
    send_frame();

    // Random phases, registers rewritten only with the parser drained
    run_phase(PHASE_BYTES - 26);
    write_regs(8'h00, 8'hFF);
    run_phase(PHASE_BYTES);
    write_regs(8'hFF, 8'h00);
    run_phase(PHASE_BYTES);
    write_regs(KP_TYPE, 8'($urandom_range(0, 255)));
    run_phase(PHASE_BYTES);
    write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(PHASE_BYTES);

    if (sb.pending_records.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending_records.size());
      sb.mismatches += sb.pending_records.size();
    end
    $display("Run covered %0d bytes in %0d frames (%0d keypoint, %0d damaged or cut)",
             bytes_sent, frames_sent, kp_frames_sent, flawed_frames, ", 5 settings");
    $display("Checked %0d results from %0d good frames, %0d mismatches",
             sb.records_checked, sb.frames_ok, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS xor_checked_keypoint_frame_parser_top");
    end else begin
      $display("FAIL xor_checked_keypoint_frame_parser_top");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("FAIL xor_checked_keypoint_frame_parser_top");
    $finish;
  end

endmodule
